[rtl/core/telnet_ansi_input_parser_core_defines.svh]
// Assertion macros for the telnet/ANSI parser checker.
`ifndef TELNET_ANSI_INPUT_PARSER_CORE_DEFINES_SVH
`define TELNET_ANSI_INPUT_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, reset masked.
`define TAP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");

// Next-cycle implication, reset masked.
`define TAP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

[rtl/core/tap_pkg.sv]
// Shared constants, codes and control/status structs of the telnet/ANSI parser.
`default_nettype none

package tap_pkg;

    localparam int PAYLOAD_LIMIT = 256;
    localparam int PAYLOAD_STORE = 64;
    localparam int CNT_W  = $clog2(PAYLOAD_LIMIT + 1);
    localparam int ADDR_W = $clog2(PAYLOAD_STORE);

    // Telnet bytes
    localparam logic [7:0] B_IAC  = 8'd255;
    localparam logic [7:0] B_SE   = 8'd240;
    localparam logic [7:0] B_SB   = 8'd250;
    localparam logic [7:0] B_WILL = 8'd251;
    localparam logic [7:0] B_WONT = 8'd252;
    localparam logic [7:0] B_DO   = 8'd253;
    localparam logic [7:0] B_DONT = 8'd254;
    localparam logic [7:0] OPT_NAWS = 8'd31;
    localparam logic [7:0] OPT_TERM = 8'd24;

    // ANSI bytes
    localparam logic [7:0] B_ESC = 8'd27;
    localparam logic [7:0] B_LBR = 8'd91;
    localparam logic [7:0] B_CR  = 8'h0d;
    localparam logic [7:0] B_BS  = 8'h08;
    localparam logic [7:0] B_DEL = 8'h7f;
    localparam logic [7:0] B_SPC = 8'h20;
    localparam logic [7:0] B_TILDE = 8'h7e;
    localparam logic [7:0] B_D0 = 8'h30;
    localparam logic [7:0] B_D9 = 8'h39;
    localparam logic [7:0] B_UA = 8'h41;
    localparam logic [7:0] B_UB = 8'h42;
    localparam logic [7:0] B_UC = 8'h43;
    localparam logic [7:0] B_UD = 8'h44;

    // Event codes
    localparam logic [3:0] EV_PUT     = 4'd0;
    localparam logic [3:0] EV_ERASE   = 4'd1;
    localparam logic [3:0] EV_NEWLINE = 4'd2;
    localparam logic [3:0] EV_UP      = 4'd3;
    localparam logic [3:0] EV_DOWN    = 4'd4;
    localparam logic [3:0] EV_RIGHT   = 4'd5;
    localparam logic [3:0] EV_LEFT    = 4'd6;
    localparam logic [3:0] EV_QUIT    = 4'd7;
    localparam logic [3:0] EV_VIEW    = 4'd8;
    localparam logic [3:0] EV_TERM    = 4'd9;

    // Controller -> datapath
    typedef struct packed {
        logic accept;     // take rx_byte, update protocol state
        logic run_init;   // name run: start at payload index 1
        logic idx_inc;    // next name byte
        logic pend_load;  // latch read data as pending name byte
        logic emit_pend;  // load pending name byte into output word
        logic pend_last;  // last flag for that word
    } tap_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic out_free;   // output register can take a word this cycle
        logic run_start;  // byte closes a TERM subnegotiation with a name window
        logic rd_zero;    // read name byte is zero
        logic rd_at_end;  // read index is the last allowed one
    } tap_status_t;

endpackage

`default_nettype wire

[rtl/core/tap_ctrl.sv]
// Controller FSM: byte intake and sequencing of terminal name runs.
`default_nettype none

module tap_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  tap_pkg::tap_status_t     status,
    output tap_pkg::tap_cmd_t        cmd
);
    import tap_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ0 = 3'd1;  // read issued, nothing pending
    localparam logic [2:0] S_READ1 = 3'd2;  // read issued, one byte pending
    localparam logic [2:0] S_EVAL0 = 3'd3;
    localparam logic [2:0] S_EVAL1 = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_stall   = !(state_reg == S_IDLE && status.out_free);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = in_valid && !in_stall;
                if (cmd.accept && status.run_start)
                begin
                    cmd.run_init = 1'b1;
                    state_next   = S_READ0;
                end
            end
            S_READ0: state_next = S_EVAL0;
            S_READ1: state_next = S_EVAL1;
            S_EVAL0:
            begin
                if (status.rd_zero)
                    state_next = S_IDLE;     // empty name
                else
                begin
                    cmd.pend_load = 1'b1;
                    if (status.rd_at_end)
                        state_next = S_FLUSH;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_READ1;
                    end
                end
            end
            S_EVAL1:
            begin
                if (status.rd_zero)
                    state_next = S_FLUSH;
                else if (status.out_free)
                begin
                    // a further byte exists, so the pending one is not last
                    cmd.emit_pend = 1'b1;
                    cmd.pend_load = 1'b1;
                    if (status.rd_at_end)
                        state_next = S_FLUSH;
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = S_READ1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (status.out_free)
                begin
                    cmd.emit_pend = 1'b1;
                    cmd.pend_last = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

[rtl/core/tap_datapath.sv]
// Datapath: telnet/ANSI decode state, payload store, name read port, output word.
`default_nettype none

module tap_datapath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [7:0]          rx_byte,
    input  wire logic                out_stall,
    output logic                     out_valid,
    output logic [3:0]               event_res,
    output logic [7:0]               char_value,
    output logic [15:0]              view_width,
    output logic [15:0]              view_height,
    output logic                     last,
    input  tap_pkg::tap_cmd_t        cmd,
    output tap_pkg::tap_status_t     status
);
    import tap_pkg::*;

    localparam logic [2:0] TEL_DATA = 3'd0;
    localparam logic [2:0] TEL_IAC  = 3'd1;
    localparam logic [2:0] TEL_WILL = 3'd2;
    localparam logic [2:0] TEL_WONT = 3'd3;
    localparam logic [2:0] TEL_DO   = 3'd4;
    localparam logic [2:0] TEL_DONT = 3'd5;
    localparam logic [2:0] TEL_SB   = 3'd6;
    localparam logic [2:0] TEL_PAY  = 3'd7;

    localparam logic [1:0] ESC_PLAIN = 2'd0;
    localparam logic [1:0] ESC_SEEN  = 2'd1;
    localparam logic [1:0] ESC_CSI   = 2'd2;

    localparam logic [1:0] MARK_NONE = 2'd0;
    localparam logic [1:0] MARK_NAWS = 2'd1;
    localparam logic [1:0] MARK_TERM = 2'd2;

    localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(PAYLOAD_LIMIT);
    localparam logic [CNT_W-1:0]  CNT_STORE = CNT_W'(PAYLOAD_STORE);
    localparam logic [CNT_W-1:0]  CNT_TOP   = CNT_W'(PAYLOAD_STORE - 1);
    localparam logic [ADDR_W-1:0] IDX_TOP   = ADDR_W'(PAYLOAD_STORE - 1);

    logic [2:0]        tel_reg,  tel_next;
    logic [1:0]        esc_reg,  esc_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic              aiac_reg, aiac_next;
    logic [1:0]        mark_reg, mark_next;

    logic [7:0]        naws0_reg, naws1_reg, naws2_reg;
    logic [ADDR_W-1:0] end_reg, end_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [7:0]        pend_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        store_mem [PAYLOAD_STORE];

    logic              out_valid_reg, out_valid_next;
    logic [3:0]        ev_reg,    ev_next;
    logic [7:0]        char_reg,  char_next;
    logic [15:0]       w_reg,     w_next;
    logic [15:0]       h_reg,     h_next;
    logic              last_reg,  last_next;

    logic              ansi_go, ansi_ev, naws_go, term_go, wr_en;
    logic [3:0]        ansi_code;
    logic [1:0]        esc_ansi;
    logic [CNT_W-1:0]  cnt_inc, end_full;
    logic              ev_valid, load_ev;

    // ANSI layer
    always_comb
    begin
        ansi_ev   = 1'b0;
        ansi_code = EV_PUT;
        esc_ansi  = esc_reg;
        unique case (esc_reg)
            ESC_PLAIN:
            begin
                priority if (rx_byte == B_ESC)
                    esc_ansi = ESC_SEEN;
                else if (rx_byte == B_BS || rx_byte == B_DEL)
                begin
                    ansi_ev   = 1'b1;
                    ansi_code = EV_ERASE;
                end
                else if (rx_byte == B_CR)
                begin
                    ansi_ev   = 1'b1;
                    ansi_code = EV_NEWLINE;
                end
                else if (rx_byte >= B_SPC && rx_byte <= B_TILDE)
                begin
                    ansi_ev   = 1'b1;
                    ansi_code = EV_PUT;
                end
                else
                    esc_ansi = ESC_PLAIN;
            end
            ESC_SEEN:
            begin
                priority if (rx_byte == B_ESC)
                begin
                    ansi_ev   = 1'b1;
                    ansi_code = EV_QUIT;
                    esc_ansi  = ESC_PLAIN;
                end
                else if (rx_byte == B_LBR)
                    esc_ansi = ESC_CSI;
                else
                    esc_ansi = ESC_PLAIN;
            end
            default:
            begin
                if (!(rx_byte >= B_D0 && rx_byte <= B_D9))
                begin
                    esc_ansi = ESC_PLAIN;
                    ansi_ev  = (rx_byte == B_UA) || (rx_byte == B_UB) ||
                               (rx_byte == B_UC) || (rx_byte == B_UD);
                    priority if (rx_byte == B_UA)
                        ansi_code = EV_UP;
                    else if (rx_byte == B_UB)
                        ansi_code = EV_DOWN;
                    else if (rx_byte == B_UC)
                        ansi_code = EV_RIGHT;
                    else
                        ansi_code = EV_LEFT;
                end
            end
        endcase
    end

    // Telnet layer
    always_comb
    begin
        tel_next  = tel_reg;
        esc_next  = esc_reg;
        cnt_next  = cnt_reg;
        aiac_next = aiac_reg;
        mark_next = mark_reg;
        ansi_go   = 1'b0;
        naws_go   = 1'b0;
        term_go   = 1'b0;
        wr_en     = 1'b0;
        cnt_inc   = cnt_reg + CNT_W'(1);
        unique case (tel_reg)
            TEL_DATA:
            begin
                if (rx_byte == B_IAC)
                    tel_next = TEL_IAC;
                else
                    ansi_go = 1'b1;
            end
            TEL_IAC:
            begin
                priority if (rx_byte == B_WILL)
                    tel_next = TEL_WILL;
                else if (rx_byte == B_WONT)
                    tel_next = TEL_WONT;
                else if (rx_byte == B_DO)
                    tel_next = TEL_DO;
                else if (rx_byte == B_DONT)
                    tel_next = TEL_DONT;
                else if (rx_byte == B_SB)
                    tel_next = TEL_SB;
                else
                begin
                    tel_next = TEL_DATA;
                    ansi_go  = (rx_byte == B_IAC);  // escaped 255
                end
            end
            TEL_SB:
            begin
                tel_next  = TEL_PAY;
                cnt_next  = '0;
                aiac_next = 1'b0;
                priority if (rx_byte == OPT_NAWS)
                    mark_next = MARK_NAWS;
                else if (rx_byte == OPT_TERM)
                    mark_next = MARK_TERM;
                else
                    mark_next = MARK_NONE;
            end
            TEL_PAY:
            begin
                if (cnt_reg == CNT_LIMIT)
                    tel_next = TEL_DATA;   // overflow: byte dropped
                else
                begin
                    wr_en    = (cnt_reg < CNT_STORE);
                    cnt_next = cnt_inc;
                    if (!aiac_reg)
                        aiac_next = (rx_byte == B_IAC);
                    else if (rx_byte == B_SE)
                    begin
                        tel_next = TEL_DATA;
                        term_go  = (mark_reg == MARK_TERM) && (cnt_inc >= CNT_W'(4));
                    end
                    else
                        aiac_next = 1'b0;
                    if (mark_reg == MARK_NAWS && cnt_inc == CNT_W'(4))
                    begin
                        naws_go   = 1'b1;
                        mark_next = MARK_NONE;
                    end
                end
            end
            default: tel_next = TEL_DATA;  // option byte after WILL/WONT/DO/DONT
        endcase
        if (ansi_go)
            esc_next = esc_ansi;
    end

    // Name window ends at count-3, clipped to the store
    always_comb
    begin
        end_full = cnt_inc - CNT_W'(3);
        if (end_full > CNT_TOP)
            end_next = IDX_TOP;
        else
            end_next = end_full[ADDR_W-1:0];
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.run_init)
            idx_next = ADDR_W'(1);
        else if (cmd.idx_inc)
            idx_next = idx_reg + ADDR_W'(1);
    end

    // Output word
    assign ev_valid = (ansi_go && ansi_ev) || naws_go;
    assign load_ev  = cmd.accept && ev_valid;

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        ev_next   = ev_reg;
        char_next = char_reg;
        w_next    = w_reg;
        h_next    = h_reg;
        last_next = last_reg;
        if (cmd.emit_pend)
        begin
            out_valid_next = 1'b1;
            ev_next   = EV_TERM;
            char_next = pend_reg;
            w_next    = '0;
            h_next    = '0;
            last_next = cmd.pend_last;
        end
        else if (load_ev)
        begin
            out_valid_next = 1'b1;
            last_next = 1'b1;
            if (naws_go)
            begin
                ev_next   = EV_VIEW;
                char_next = '0;
                w_next    = {naws0_reg, naws1_reg};
                h_next    = {naws2_reg, rx_byte};
            end
            else
            begin
                ev_next   = ansi_code;
                char_next = (ansi_code == EV_PUT) ? rx_byte : 8'd0;
                w_next    = '0;
                h_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tel_reg       <= TEL_DATA;
            esc_reg       <= ESC_PLAIN;
            cnt_reg       <= '0;
            aiac_reg      <= 1'b0;
            mark_reg      <= MARK_NONE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            end_reg       <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            if (cmd.accept)
            begin
                tel_reg  <= tel_next;
                esc_reg  <= esc_next;
                cnt_reg  <= cnt_next;
                aiac_reg <= aiac_next;
                mark_reg <= mark_next;
                if (term_go)
                    end_reg <= end_next;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        ev_reg   <= ev_next;
        char_reg <= char_next;
        w_reg    <= w_next;
        h_reg    <= h_next;
        last_reg <= last_next;
        if (cmd.pend_load)
            pend_reg <= rd_data_reg;
        if (cmd.accept && wr_en)
        begin
            // first three payload bytes kept aside for NAWS
            if (cnt_reg == CNT_W'(0))
                naws0_reg <= rx_byte;
            if (cnt_reg == CNT_W'(1))
                naws1_reg <= rx_byte;
            if (cnt_reg == CNT_W'(2))
                naws2_reg <= rx_byte;
        end
    end

    // Payload store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept && wr_en)
            store_mem[cnt_reg[ADDR_W-1:0]] <= rx_byte;
        rd_data_reg <= store_mem[idx_reg];
    end

    assign status.out_free  = !out_valid_reg || !out_stall;
    assign status.run_start = term_go;
    assign status.rd_zero   = (rd_data_reg == 8'd0);
    assign status.rd_at_end = (idx_reg == end_reg);

    assign out_valid   = out_valid_reg;
    assign event_res   = ev_reg;
    assign char_value  = char_reg;
    assign view_width  = w_reg;
    assign view_height = h_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

[rtl/core/telnet_ansi_input_parser_core.sv]
// Top level of the telnet/ANSI input parser: controller plus datapath.
//
// Takes one received byte per cycle on the input channel and turns it into
// edit events: telnet IAC commands and subnegotiations are stripped, NAWS
// yields one set_view word, and ANSI keys yield put/erase/newline/cursor/
// clear_quit words. Every byte is taken as it arrives while the output
// register is free or being drained, so a steady stream runs at one byte per
// clock. The exception is IAC SE closing a TERM subnegotiation: the name is
// read back from the 64-byte payload RAM one byte at a time through its
// single registered read port. Each name byte is read back in turn, plus the
// zero byte that ends a short name, and then the last word is sent; any
// output stall lengthens the run. Input is stalled for the whole run. The
// payload RAM needs no clearing after reset; only bytes written in the
// current subnegotiation are ever read.
`default_nettype none

module telnet_ansi_input_parser_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  rx_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [3:0]       event_res,
    output logic [7:0]       char_value,
    output logic [15:0]      view_width,
    output logic [15:0]      view_height,
    output logic             last
);
    import tap_pkg::*;

    tap_cmd_t    cmd;
    tap_status_t status;

    tap_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    tap_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .event_res   (event_res),
        .char_value  (char_value),
        .view_width  (view_width),
        .view_height (view_height),
        .last        (last),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

`default_nettype wire

[rtl/core/tap_checker.sv]
// Port-level checker for the telnet/ANSI parser, bound to the top level.
`default_nettype none

`include "telnet_ansi_input_parser_core_defines.svh"

module tap_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [3:0]  event_res,
    input  wire logic [7:0]  char_value,
    input  wire logic [15:0] view_width,
    input  wire logic [15:0] view_height,
    input  wire logic        last
);
    import tap_pkg::*;

    logic        in_word;
    logic        run_open;
    logic        view_zero;
    logic        put_ok;
    logic [44:0] out_bits;

    assign in_word   = in_valid && !in_stall;
    assign run_open  = out_valid && event_res == EV_TERM && !last;
    assign view_zero = view_width == 16'd0 && view_height == 16'd0;
    assign put_ok    = char_value >= B_SPC && char_value <= B_TILDE;
    assign out_bits  = {event_res, char_value, view_width, view_height, last};

    // a held word keeps all its fields
    `TAP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_bits))

    // only name runs carry last low
    `TAP_ASSERT_NOW(a_single_last, clk, rst_n, out_valid && event_res != EV_TERM, last)

    // window size only travels with set_view
    `TAP_ASSERT_NOW(a_view_zero, clk, rst_n, out_valid && event_res != EV_VIEW, view_zero)

    // no byte is taken while a name run is still open
    `TAP_ASSERT_NOW(a_run_stalls_input, clk, rst_n, run_open, !in_word)

    // printable byte for put
    `TAP_ASSERT_NOW(a_put_char, clk, rst_n, out_valid && event_res == EV_PUT, put_ok)

endmodule

bind telnet_ansi_input_parser_core tap_checker u_tap_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .event_res   (event_res),
    .char_value  (char_value),
    .view_width  (view_width),
    .view_height (view_height),
    .last        (last)
);

`default_nettype wire

[tb/telnet_ansi_input_parser_core_tb.sv]
// Self-checking testbench for the telnet/ANSI input parser core.
`timescale 1ns / 1ps

module telnet_ansi_input_parser_core_tb;
    import tap_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 150;
    localparam int RANDOM_BYTES = 50;
    localparam int MAX_REPORTS  = 25;

    localparam logic [7:0] CMD_NOP    = 8'd241;
    localparam logic [7:0] OPT_ECHO   = 8'd1;
    localparam logic [7:0] OPT_SGA    = 8'd3;
    localparam logic [7:0] OPT_STATUS = 8'd5;

    typedef enum logic [2:0] {
        TP_DATA, TP_IAC, TP_WILL, TP_WONT, TP_DO, TP_DONT, TP_SB, TP_PAY
    } telnet_phase_t;
    typedef enum logic [1:0] {ES_PLAIN, ES_ESC, ES_CSI} esc_phase_t;
    typedef enum logic [1:0] {OM_NONE, OM_NAWS, OM_TERM} sub_option_t;

    typedef struct packed {
        logic [3:0]  code;
        logic [7:0]  ch;
        logic [15:0] wid;
        logic [15:0] hgt;
        logic        fin;
    } edit_event_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic [7:0]  rx_byte   = 8'd0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [3:0]  event_res;
    logic [7:0]  char_value;
    logic [15:0] view_width;
    logic [15:0] view_height;
    logic        last;

    // parser state mirror
    telnet_phase_t     tel_phase  = TP_DATA;
    esc_phase_t        esc_phase  = ES_PLAIN;
    logic [CNT_W-1:0]  sub_count  = '0;
    logic              sub_iac    = 1'b0;
    sub_option_t       sub_option = OM_NONE;
    logic [7:0]        sub_mem [PAYLOAD_STORE];

    edit_event_t predicted_events[$];

    int  err_count   = 0;
    int  bytes_sent  = 0;
    int  events_seen = 0;
    int  names_seen  = 0;
    int  views_seen  = 0;
    int  cycle_count = 0;
    logic calm       = 1'b0;

    telnet_ansi_input_parser_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .rx_byte     (rx_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_res   (event_res),
        .char_value  (char_value),
        .view_width  (view_width),
        .view_height (view_height),
        .last        (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(99) < 11);

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void add_event(input logic [3:0] code, input logic [7:0] ch,
                                      input logic [15:0] wid, input logic [15:0] hgt,
                                      input logic fin);
        edit_event_t e;
        e.code = code;
        e.ch   = ch;
        e.wid  = wid;
        e.hgt  = hgt;
        e.fin  = fin;
        predicted_events.push_back(e);
    endfunction

    function automatic void ansi_step(input logic [7:0] c);
        case (esc_phase)
            ES_PLAIN:
            begin
                if (c == B_ESC)
                    esc_phase = ES_ESC;
                else if (c == B_BS || c == B_DEL)
                    add_event(EV_ERASE, 8'd0, 16'd0, 16'd0, 1'b1);
                else if (c == B_CR)
                    add_event(EV_NEWLINE, 8'd0, 16'd0, 16'd0, 1'b1);
                else if (c >= B_SPC && c <= B_TILDE)
                    add_event(EV_PUT, c, 16'd0, 16'd0, 1'b1);
            end
            ES_ESC:
            begin
                if (c == B_ESC)
                begin
                    add_event(EV_QUIT, 8'd0, 16'd0, 16'd0, 1'b1);
                    esc_phase = ES_PLAIN;
                end
                else if (c == B_LBR)
                    esc_phase = ES_CSI;
                else
                    esc_phase = ES_PLAIN;
            end
            default:
            begin
                // digits keep the CSI open, anything else closes it
                if (c < B_D0 || c > B_D9)
                begin
                    esc_phase = ES_PLAIN;
                    case (c)
                        B_UA: add_event(EV_UP, 8'd0, 16'd0, 16'd0, 1'b1);
                        B_UB: add_event(EV_DOWN, 8'd0, 16'd0, 16'd0, 1'b1);
                        B_UC: add_event(EV_RIGHT, 8'd0, 16'd0, 16'd0, 1'b1);
                        B_UD: add_event(EV_LEFT, 8'd0, 16'd0, 16'd0, 1'b1);
                        default: ;
                    endcase
                end
            end
        endcase
    endfunction

    // name sits at payload index 1 up to count-3, ends at a zero byte or the store end
    function automatic void emit_term_name();
        int stop_at;
        int len;
        int i;
        if (sub_count >= 4)
        begin
            stop_at = int'(sub_count) - 3;
            len = 0;
            for (i = 1; i <= stop_at && i < PAYLOAD_STORE; i++)
            begin
                if (sub_mem[i] == 8'd0)
                    break;
                len++;
            end
            for (i = 1; i <= len; i++)
                add_event(EV_TERM, sub_mem[i], 16'd0, 16'd0, i == len);
        end
    endfunction

    function automatic void payload_step(input logic [7:0] c);
        if (sub_count >= PAYLOAD_LIMIT)
            tel_phase = TP_DATA;
        else
        begin
            if (sub_count < PAYLOAD_STORE)
                sub_mem[sub_count[ADDR_W-1:0]] = c;
            sub_count = sub_count + 1'b1;
            if (!sub_iac)
                sub_iac = (c == B_IAC);
            else if (c == B_SE)
            begin
                if (sub_option == OM_TERM)
                    emit_term_name();
                tel_phase = TP_DATA;
            end
            else
                sub_iac = 1'b0;
            if (sub_option == OM_NAWS && sub_count == 4)
            begin
                add_event(EV_VIEW, 8'd0, {sub_mem[0], sub_mem[1]},
                          {sub_mem[2], sub_mem[3]}, 1'b1);
                sub_option = OM_NONE;
            end
        end
    endfunction

    function automatic void parse_byte(input logic [7:0] c);
        case (tel_phase)
            TP_DATA:
            begin
                if (c == B_IAC)
                    tel_phase = TP_IAC;
                else
                    ansi_step(c);
            end
            TP_IAC:
            begin
                case (c)
                    B_WILL: tel_phase = TP_WILL;
                    B_WONT: tel_phase = TP_WONT;
                    B_DO:   tel_phase = TP_DO;
                    B_DONT: tel_phase = TP_DONT;
                    B_SB:   tel_phase = TP_SB;
                    default:
                    begin
                        tel_phase = TP_DATA;
                        if (c == B_IAC)
                            ansi_step(c);
                    end
                endcase
            end
            TP_SB:
            begin
                tel_phase = TP_PAY;
                sub_count = '0;
                sub_iac   = 1'b0;
                if (c == OPT_NAWS)
                    sub_option = OM_NAWS;
                else if (c == OPT_TERM)
                    sub_option = OM_TERM;
                else
                    sub_option = OM_NONE;
            end
            TP_PAY:
                payload_step(c);
            default:
                tel_phase = TP_DATA;
        endcase
    endfunction

    always @(posedge clk)
    begin
        edit_event_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            events_seen++;
            if (event_res == EV_TERM)
                names_seen++;
            if (event_res == EV_VIEW)
                views_seen++;
            if (predicted_events.size() == 0)
                report_mismatch($sformatf("word %0d unexpected, event %0d",
                                          events_seen, event_res));
            else
            begin
                want = predicted_events.pop_front();
                if (event_res !== want.code)
                    report_mismatch($sformatf("word %0d event_res %0d, want %0d",
                                              events_seen, event_res, want.code));
                if (char_value !== want.ch)
                    report_mismatch($sformatf("word %0d char_value %h, want %h",
                                              events_seen, char_value, want.ch));
                if (view_width !== want.wid)
                    report_mismatch($sformatf("word %0d view_width %h, want %h",
                                              events_seen, view_width, want.wid));
                if (view_height !== want.hgt)
                    report_mismatch($sformatf("word %0d view_height %h, want %h",
                                              events_seen, view_height, want.hgt));
                if (last !== want.fin)
                    report_mismatch($sformatf("word %0d last %b, want %b",
                                              events_seen, last, want.fin));
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        // idle gaps added at random, each with a chance of about 11 in a hundred
        while (!calm && $urandom_range(99) < 11)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        parse_byte(b);
        bytes_sent++;
    endtask

    // data byte inside a subnegotiation, IAC doubled
    task automatic send_escaped(input logic [7:0] b);
        send_byte(b);
        if (b == B_IAC)
            send_byte(b);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (predicted_events.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_ansi_keys();
        send_byte(B_SPC);
        send_byte(B_TILDE);
        send_byte(8'h00);
        send_byte(B_BS);
        send_byte(B_DEL);
        send_byte(B_CR);
        send_byte(B_ESC);
        send_byte(B_ESC);
        send_byte(B_ESC);
        send_byte("q");
        send_byte(B_ESC);
        send_byte(B_LBR);
        send_byte(B_D0);
        send_byte(B_D9);
        send_byte(B_UA);
        for (int k = 1; k < 4; k++)
        begin
            send_byte(B_ESC);
            send_byte(B_LBR);
            send_byte(8'(B_UA + k));
        end
        send_byte(B_ESC);
        send_byte(B_LBR);
        send_byte("z");
        wait_for_results();
    endtask

    task automatic test_telnet_commands();
        // IAC IAC lands in the ANSI layer and cancels the pending ESC
        send_byte(B_ESC);
        send_byte(B_IAC);
        send_byte(B_IAC);
        send_byte(B_LBR);
        send_byte(B_IAC);
        send_byte(B_WILL);
        send_byte(OPT_ECHO);
        send_byte(B_IAC);
        send_byte(B_WONT);
        send_byte(OPT_SGA);
        send_byte(B_IAC);
        send_byte(B_DO);
        send_byte(OPT_NAWS);
        send_byte(B_IAC);
        send_byte(B_DONT);
        send_byte(OPT_TERM);
        send_byte(B_IAC);
        send_byte(CMD_NOP);
        send_byte("a");
        wait_for_results();
    endtask

    task automatic test_window_size();
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(OPT_NAWS);
        send_byte(8'h00);
        send_byte(8'h50);
        send_byte(8'h00);
        send_byte(8'h18);
        send_byte(B_IAC);
        send_byte(B_SE);
        // fourth payload byte is the closing SE
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(OPT_NAWS);
        send_escaped(B_IAC);
        send_byte(B_IAC);
        send_byte(B_SE);
        wait_for_results();
    endtask

    task automatic test_terminal_name();
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(OPT_TERM);
        send_byte(8'h00);
        send_byte("x");
        send_byte("t");
        send_byte("e");
        send_byte("r");
        send_byte("m");
        send_byte(B_IAC);
        send_byte(B_SE);
        // too short for a name
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(OPT_TERM);
        send_byte(8'h00);
        send_byte(B_IAC);
        send_byte(B_SE);
        // name starts with a zero byte
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(OPT_TERM);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte("a");
        send_byte(B_IAC);
        send_byte(B_SE);
        // unknown option after a TERM mark
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(OPT_STATUS);
        send_byte("b");
        send_byte("c");
        send_byte("d");
        send_byte(B_IAC);
        send_byte(B_SE);
        wait_for_results();
    endtask

    task automatic test_payload_limits();
        logic [7:0] v;
        // name runs past the store end and is cut there
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(OPT_TERM);
        send_byte(8'h00);
        repeat (PAYLOAD_STORE)
        begin
            v = 8'($urandom_range(B_TILDE, B_SPC));
            send_byte(v);
        end
        send_byte(B_IAC);
        send_byte(B_SE);
        wait_for_results();
        // payload fills the limit, one byte past it is dropped; no idling here
        calm = 1'b1;
        send_byte(B_IAC);
        send_byte(B_SB);
        send_byte(OPT_STATUS);
        repeat (PAYLOAD_LIMIT)
        begin
            v = 8'($urandom_range(254));
            send_byte(v);
        end
        send_byte("Z");
        send_byte("k");
        wait_for_results();
        calm = 1'b0;
    endtask

    task automatic test_random_traffic();
        int   start;
        int   pick;
        int   r;
        int   n;
        logic paused;
        logic [7:0] v;
        start  = bytes_sent;
        paused = 1'b0;
        while (bytes_sent - start < RANDOM_BYTES)
        begin
            if (!paused && bytes_sent - start >= RANDOM_BYTES / 2)
            begin
                wait_for_results();
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 26)
            begin
                repeat ($urandom_range(8, 1))
                begin
                    r = $urandom_range(9);
                    if (r == 0)
                        v = $urandom_range(1) ? B_BS : B_DEL;
                    else if (r == 1)
                        v = B_CR;
                    else
                        v = 8'($urandom_range(B_TILDE, B_SPC));
                    send_byte(v);
                end
            end
            else if (pick < 42)
            begin
                send_byte(B_ESC);
                r = $urandom_range(9);
                if (r < 6)
                begin
                    send_byte(B_LBR);
                    repeat ($urandom_range(2))
                    begin
                        v = 8'($urandom_range(B_D9, B_D0));
                        send_byte(v);
                    end
                    if ($urandom_range(7) != 0)
                        v = 8'(B_UA + $urandom_range(3));
                    else
                        v = 8'($urandom_range(255));
                    send_byte(v);
                end
                else if (r < 8)
                    send_byte(B_ESC);
                else
                begin
                    v = 8'($urandom_range(255));
                    send_byte(v);
                end
            end
            else if (pick < 54)
            begin
                send_byte(B_IAC);
                r = $urandom_range(5);
                if (r < 4)
                begin
                    send_byte(8'(B_WILL + r));
                    v = 8'($urandom_range(255));
                    send_byte(v);
                end
                else if (r == 4)
                    send_byte(B_IAC);
                else
                begin
                    v = 8'($urandom_range(255));
                    send_byte(v);
                end
            end
            else if (pick < 66)
            begin
                send_byte(B_IAC);
                send_byte(B_SB);
                send_byte(OPT_NAWS);
                repeat (4)
                begin
                    v = 8'($urandom_range(255));
                    send_escaped(v);
                end
                send_byte(B_IAC);
                send_byte(B_SE);
            end
            else if (pick < 84)
            begin
                send_byte(B_IAC);
                send_byte(B_SB);
                send_byte(OPT_TERM);
                send_byte($urandom_range(1) ? 8'h00 : 8'h01);
                n = ($urandom_range(7) == 0) ? $urandom_range(70, 40) : $urandom_range(12);
                repeat (n)
                begin
                    if ($urandom_range(19) == 0)
                        v = 8'($urandom_range(255));
                    else
                        v = 8'($urandom_range(B_TILDE, B_SPC));
                    send_escaped(v);
                end
                // now and then the closing IAC SE is left off
                if ($urandom_range(15) != 0)
                begin
                    send_byte(B_IAC);
                    send_byte(B_SE);
                end
            end
            else if (pick < 90)
            begin
                send_byte(B_IAC);
                send_byte(B_SB);
                do
                    v = 8'($urandom_range(255));
                while (v == OPT_NAWS || v == OPT_TERM);
                send_byte(v);
                repeat ($urandom_range(5))
                begin
                    v = 8'($urandom_range(255));
                    send_escaped(v);
                end
                send_byte(B_IAC);
                send_byte(B_SE);
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                begin
                    v = 8'($urandom_range(255));
                    send_byte(v);
                end
            end
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ansi_keys();
        test_telnet_commands();
        test_window_size();
        test_terminal_name();
        test_payload_limits();
        test_random_traffic();
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Sent %0d bytes; checked %0d words (%0d name bytes, %0d window sizes)",
                 bytes_sent, events_seen, names_seen, views_seen);
        $display("Mismatches: %0d", err_count);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
